@@ sv/giou_pkg.sv @@
package giou_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_MATCH = 2'd1,
        CMD_END   = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AREA,
        ST_SCAN,
        ST_EMIT,
        ST_FLUSH,
        ST_FLUSH_EMIT
    } state_t;

    // queued command word between front and back
    typedef struct packed {
        cmd_t        cmd;
        logic [15:0] box_x;
        logic [15:0] box_y;
        logic [15:0] box_w;
        logic [15:0] box_h;
        logic [6:0]  class_id;
    } item_t;

    localparam int ITEM_W = $bits(item_t);
    localparam logic [7:0] NO_CLASS = 8'hFF;

endpackage

@@ sv/giou_front.sv @@
// Accept input words, drop unused commands, and queue the rest in a small FIFO.
module giou_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  giou_pkg::item_t in_item,
    output logic            q_valid,
    input  logic            q_ready,
    output giou_pkg::item_t q_item
);
    import giou_pkg::*;

    localparam int DEPTH = 4;

    item_t      fifo_reg [DEPTH];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg;
    logic       push, pop;

    assign in_ready = (count_reg != 3'(DEPTH));
    assign push     = in_valid && in_ready && (in_item.cmd != CMD_NONE);
    assign q_valid  = (count_reg != 3'd0);
    assign pop      = q_valid && q_ready;
    assign q_item   = fifo_reg[rd_ptr_reg];

    // store queued words
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= in_item;
        end
    end

    // advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + 3'(push) - 3'(pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'(DEPTH)) else $error("queue overflow");
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 3'd1)
        else $error("push lost");
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> count_reg == $past(count_reg) - 3'd1)
        else $error("pop lost");
`endif
endmodule

@@ sv/giou_back.sv @@
// Execute load, match and end-of-image commands against the truth store.
module giou_back #(
    parameter int MAX_TRUTHS = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_ready,
    input  giou_pkg::item_t q_item,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_truth_class,
    output logic [7:0]      out_predicted_class,
    output logic            out_last
);
    import giou_pkg::*;

    localparam int IW = (MAX_TRUTHS > 1) ? $clog2(MAX_TRUTHS) : 1;
    localparam int FW = $clog2(MAX_TRUTHS + 1);

    // store
    logic [63:0]     box_mem [MAX_TRUTHS];
    logic [6:0]      label_mem [MAX_TRUTHS];
    logic [MAX_TRUTHS-1:0] valid_reg, valid_next;
    logic [FW-1:0]   fill_reg, fill_next;

    state_t          state_reg, state_next;
    item_t           cur_reg, cur_next;
    logic [IW:0]     idx_reg, idx_next;
    logic [32:0]     darea_reg, darea_next;
    logic            found_reg, found_next;
    logic [IW-1:0]   best_reg, best_next;
    logic [32:0]     bi_reg, bi_next;
    logic [33:0]     bu_reg, bu_next;

    logic [63:0]     rd_box_reg;
    logic [6:0]      rd_label_reg;
    logic            rd_ok_reg;
    logic [IW-1:0]   rd_idx_reg;

    logic [7:0]      o_tc_reg, o_tc_next, o_pc_reg, o_pc_next;
    logic            o_last_reg, o_last_next, o_v_reg, o_v_next;

    // pipeline for IoU: stage A overlaps, stage B products, stage C cross-mul
    logic [15:0]     ow_a, oh_a;
    logic [32:0]     in_b, ta_b;
    logic [33:0]     un_b;
    logic            ok_b_reg, ok_c_reg;
    logic [IW-1:0]   idx_b_reg, idx_c_reg;
    logic [32:0]     ci_reg, ci_c_reg;
    logic [33:0]     cu_reg, cu_c_reg;
    logic [15:0]     ow_reg, oh_reg;
    logic [31:0]     tarea_reg;
    logic            ok_a_reg;
    logic [IW-1:0]   idx_a_reg;
    logic [66:0]     lhs, rhs;
    logic            better;
    logic            scan_rd, scan_done;
    logic            label_ok;

    function automatic logic [15:0] ovl(input logic [15:0] a0, input logic [15:0] al,
                                        input logic [15:0] b0, input logic [15:0] bl);
        logic [16:0] a1, b1, lo, hi;
        a1 = {1'b0, a0} + {1'b0, al};
        b1 = {1'b0, b0} + {1'b0, bl};
        lo = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
        hi = (a1 < b1) ? a1 : b1;
        return (hi > lo) ? 16'(hi - lo) : 16'd0;
    endfunction

    assign q_ready = (state_reg == ST_IDLE);
    assign scan_rd = (state_reg == ST_SCAN || state_reg == ST_FLUSH) &&
                     (idx_reg < (IW+1)'(MAX_TRUTHS));

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (q_valid && q_ready && q_item.cmd == CMD_LOAD && fill_reg < FW'(MAX_TRUTHS))
        begin
            box_mem[fill_reg[IW-1:0]]   <= {q_item.box_h, q_item.box_w,
                                            q_item.box_y, q_item.box_x};
            label_mem[fill_reg[IW-1:0]] <= q_item.class_id;
        end
        rd_box_reg   <= box_mem[idx_reg[IW-1:0]];
        rd_label_reg <= label_mem[idx_reg[IW-1:0]];
        rd_idx_reg   <= idx_reg[IW-1:0];
    end

    // IoU datapath
    assign ow_a = ovl(rd_box_reg[15:0], rd_box_reg[47:32], cur_reg.box_x, cur_reg.box_w);
    assign oh_a = ovl(rd_box_reg[31:16], rd_box_reg[63:48], cur_reg.box_y, cur_reg.box_h);
    assign in_b = {1'b0, 32'(ow_reg) * 32'(oh_reg)};
    assign ta_b = {1'b0, tarea_reg};
    assign un_b = {1'b0, ta_b} + {1'b0, darea_reg} - {1'b0, in_b};
    assign lhs  = 67'(ci_c_reg) * 67'(bu_reg);
    assign rhs  = 67'(bi_reg) * 67'(cu_c_reg);
    assign better = !found_reg || (lhs > rhs);
    assign scan_done = (idx_reg == (IW+1)'(MAX_TRUTHS)) && !rd_ok_reg && !ok_a_reg &&
                       !ok_b_reg && !ok_c_reg;
    // the read port has delivered the winner's label, or there is no winner
    assign label_ok = !found_reg || (rd_idx_reg == best_reg);

    always_ff @(posedge clk)
    begin
        ow_reg    <= ow_a;
        oh_reg    <= oh_a;
        tarea_reg <= rd_box_reg[47:32] * rd_box_reg[63:48];
        idx_a_reg <= rd_idx_reg;
        idx_b_reg <= idx_a_reg;
        idx_c_reg <= idx_b_reg;
        ci_reg    <= (un_b == 34'd0) ? 33'd0 : in_b;
        cu_reg    <= (un_b == 34'd0) ? 34'd1 : un_b;
        ci_c_reg  <= ci_reg;
        cu_c_reg  <= cu_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ok_reg <= 1'b0;
            ok_a_reg  <= 1'b0;
            ok_b_reg  <= 1'b0;
            ok_c_reg  <= 1'b0;
        end
        else
        begin
            rd_ok_reg <= scan_rd && (state_reg == ST_SCAN) && valid_reg[idx_reg[IW-1:0]];
            ok_a_reg  <= rd_ok_reg;
            ok_b_reg  <= ok_a_reg;
            ok_c_reg  <= ok_b_reg;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_item.cmd)
                        CMD_MATCH: state_next = ST_AREA;
                        CMD_END:   state_next = ST_FLUSH;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_AREA:       state_next = ST_SCAN;
            ST_SCAN:       state_next = scan_done ? ST_EMIT : ST_SCAN;
            ST_EMIT:
            begin
                state_next = ((!o_v_reg || out_ready) && label_ok) ? ST_IDLE : ST_EMIT;
            end
            ST_FLUSH:
            begin
                if (idx_reg == (IW+1)'(MAX_TRUTHS))
                begin
                    state_next = ST_IDLE;
                end
                else if (valid_reg[idx_reg[IW-1:0]])
                begin
                    state_next = ST_FLUSH_EMIT;
                end
            end
            ST_FLUSH_EMIT: state_next = (!o_v_reg || out_ready) ? ST_FLUSH : ST_FLUSH_EMIT;
            default:       state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        logic [MAX_TRUTHS-1:0] rest;
        rest        = '0;
        cur_next    = cur_reg;
        idx_next    = idx_reg;
        darea_next  = darea_reg;
        found_next  = found_reg;
        best_next   = best_reg;
        bi_next     = bi_reg;
        bu_next     = bu_reg;
        valid_next  = valid_reg;
        fill_next   = fill_reg;
        o_tc_next   = o_tc_reg;
        o_pc_next   = o_pc_reg;
        o_last_next = o_last_reg;
        o_v_next    = o_v_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (q_valid)
                begin
                    cur_next   = q_item;
                    found_next = 1'b0;
                    bi_next    = '0;
                    bu_next    = 34'd1;
                    if (q_item.cmd == CMD_LOAD && fill_reg < FW'(MAX_TRUTHS))
                    begin
                        valid_next[fill_reg[IW-1:0]] = 1'b1;
                        fill_next = fill_reg + FW'(1);
                    end
                end
            end
            ST_AREA:
            begin
                darea_next = {1'b0, 32'(cur_reg.box_w) * 32'(cur_reg.box_h)};
            end
            ST_SCAN:
            begin
                if (idx_reg != (IW+1)'(MAX_TRUTHS))
                begin
                    idx_next = idx_reg + (IW+1)'(1);
                end
                if (ok_c_reg && better)
                begin
                    found_next = 1'b1;
                    best_next  = idx_c_reg;
                    bi_next    = ci_c_reg;
                    bu_next    = cu_c_reg;
                end
            end
            ST_EMIT:
            begin
                if ((!o_v_reg || out_ready) && label_ok)
                begin
                    o_v_next    = 1'b1;
                    o_tc_next   = found_reg ? {1'b0, rd_label_reg} : NO_CLASS;
                    o_pc_next   = {1'b0, cur_reg.class_id};
                    o_last_next = 1'b1;
                    if (found_reg)
                    begin
                        valid_next[best_reg] = 1'b0;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (idx_reg == (IW+1)'(MAX_TRUTHS))
                begin
                    fill_next = '0;
                end
                else if (!valid_reg[idx_reg[IW-1:0]])
                begin
                    idx_next = idx_reg + (IW+1)'(1);
                end
            end
            ST_FLUSH_EMIT:
            begin
                if (!o_v_reg || out_ready)
                begin
                    rest = valid_reg;
                    rest[idx_reg[IW-1:0]] = 1'b0;
                    rest = rest >> idx_reg[IW-1:0];
                    o_v_next    = 1'b1;
                    o_tc_next   = {1'b0, rd_label_reg};
                    o_pc_next   = NO_CLASS;
                    o_last_next = (rest == '0);
                    valid_next[idx_reg[IW-1:0]] = 1'b0;
                    idx_next    = idx_reg + (IW+1)'(1);
                end
            end
            default:
            begin
                o_v_next = o_v_reg;
            end
        endcase
    end

    assign out_valid           = o_v_reg;
    assign out_truth_class     = o_tc_reg;
    assign out_predicted_class = o_pc_reg;
    assign out_last            = o_last_reg;

    // the emit state reads the label of the chosen entry through the memory port
    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        darea_reg  <= darea_next;
        best_reg   <= best_next;
        bi_reg     <= bi_next;
        bu_reg     <= bu_next;
        o_tc_reg   <= o_tc_next;
        o_pc_reg   <= o_pc_next;
        o_last_reg <= o_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            found_reg <= 1'b0;
            valid_reg <= '0;
            fill_reg  <= '0;
            o_v_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            found_reg <= found_next;
            valid_reg <= valid_next;
            fill_reg  <= fill_next;
            o_v_reg   <= o_v_next;
            // point the read port at the winner when the scan ends
            if (state_reg == ST_SCAN && scan_done)
            begin
                idx_reg <= {1'b0, best_next};
            end
            else
            begin
                idx_reg <= idx_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(MAX_TRUTHS)) else $error("fill out of range");
    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH && state_next == ST_IDLE) |=> valid_reg == '0)
        else $error("store not cleared");
    a_match_removes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && state_next == ST_IDLE && found_reg) |=>
        !valid_reg[$past(best_reg)]) else $error("match not removed");
`endif
endmodule

@@ sv/greedy_iou_detection_matcher.sv @@
// Greedy IoU matcher. Load words fill a truth store of MAX_TRUTHS entries
// (extra loads dropped); a match word scans every store slot through a
// one-entry-per-cycle IoU pipeline and emits (truth class, detection class).
// End of image walks the store once emitting (class, -1) pairs, last on the
// final one. A four-word queue separates acceptance from execution; one
// output register holds results.
module greedy_iou_detection_matcher #(
    parameter int MAX_TRUTHS  = 64,
    parameter int NUM_CLASSES = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // box_x, box_y, box_w, box_h, class_id, pad
    input  logic [1:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // truth_class, predicted_class
    output logic        m_tlast
);
    import giou_pkg::*;

    item_t in_item, q_item;
    logic  q_valid, q_ready;

    assign in_item.cmd      = cmd_t'(s_tuser);
    assign in_item.box_x    = s_tdata[15:0];
    assign in_item.box_y    = s_tdata[31:16];
    assign in_item.box_w    = s_tdata[47:32];
    assign in_item.box_h    = s_tdata[63:48];
    assign in_item.class_id = s_tdata[70:64];

    giou_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_item(in_item),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    giou_back #(.MAX_TRUTHS(MAX_TRUTHS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_truth_class(m_tdata[7:0]), .out_predicted_class(m_tdata[15:8]),
        .out_last(m_tlast)
    );

`ifndef SYNTHESIS
    a_classes: assert property (@(posedge clk) disable iff (!rst_n)
        NUM_CLASSES >= 2) else $error("bad class count");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("output word dropped");
    a_ghost: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[7:0] == 8'hFF && m_tdata[15:8] == 8'hFF))
        else $error("empty pair");
`endif
endmodule

@@ dv/greedy_iou_detection_matcher_tb.sv @@
`timescale 1ns / 1ps

module greedy_iou_detection_matcher_tb;
    import giou_pkg::*;

    localparam int MAX_TRUTHS  = 64;
    localparam int STALL_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 300;
    localparam int HOLD_CYCLES = 400;

    // one expected result word
    typedef struct {
        logic [7:0] truth_class;
        logic [7:0] predicted_class;
        logic       last;
    } pair_t;

    // predicts matcher output pairs and checks the ones that come out
    class pair_scoreboard;
        logic        slot_valid [MAX_TRUTHS];
        logic [15:0] slot_x [MAX_TRUTHS];
        logic [15:0] slot_y [MAX_TRUTHS];
        logic [15:0] slot_w [MAX_TRUTHS];
        logic [15:0] slot_h [MAX_TRUTHS];
        logic [6:0]  slot_class [MAX_TRUTHS];
        int          fill_count;
        pair_t       pending_pairs[$];
        int          errors;

        function new();
            foreach (slot_valid[i]) slot_valid[i] = 1'b0;
            fill_count = 0;
            errors = 0;
        endfunction

        function automatic logic [16:0] overlap(logic [15:0] a0, logic [15:0] alen,
                                                logic [15:0] b0, logic [15:0] blen);
            logic [16:0] a1, b1, lo, hi;
            a1 = {1'b0, a0} + alen;
            b1 = {1'b0, b0} + blen;
            lo = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
            hi = (a1 < b1) ? a1 : b1;
            return (hi > lo) ? hi - lo : 17'd0;
        endfunction

        // note an accepted command word and queue the pairs it causes
        function void note_item(cmd_t cmd, logic [15:0] x, logic [15:0] y,
                                logic [15:0] w, logic [15:0] h, logic [6:0] cls);
            int best;
            logic [63:0] bi, bu, ci, cu, inter, uni;
            logic [127:0] lhs, rhs;
            pair_t p;
            case (cmd)
                CMD_LOAD:
                begin
                    if (fill_count < MAX_TRUTHS)
                    begin
                        slot_valid[fill_count] = 1'b1;
                        slot_x[fill_count] = x;
                        slot_y[fill_count] = y;
                        slot_w[fill_count] = w;
                        slot_h[fill_count] = h;
                        slot_class[fill_count] = cls;
                        fill_count++;
                    end
                end
                CMD_MATCH:
                begin
                    best = -1;
                    bi = 0;
                    bu = 1;
                    for (int i = 0; i < MAX_TRUTHS; i++)
                    begin
                        if (!slot_valid[i]) continue;
                        inter = 64'(overlap(slot_x[i], slot_w[i], x, w))
                              * 64'(overlap(slot_y[i], slot_h[i], y, h));
                        uni = 64'(slot_w[i]) * 64'(slot_h[i]) + 64'(w) * 64'(h) - inter;
                        if (uni == 0)
                        begin
                            ci = 0;
                            cu = 1;
                        end
                        else
                        begin
                            ci = inter;
                            cu = uni;
                        end
                        lhs = 128'(ci) * 128'(bu);
                        rhs = 128'(bi) * 128'(cu);
                        if (best < 0 || lhs > rhs)
                        begin
                            best = i;
                            bi = ci;
                            bu = cu;
                        end
                    end
                    if (best >= 0)
                    begin
                        p.truth_class = {1'b0, slot_class[best]};
                        slot_valid[best] = 1'b0;
                    end
                    else
                        p.truth_class = NO_CLASS;
                    p.predicted_class = {1'b0, cls};
                    p.last = 1'b1;
                    pending_pairs.push_back(p);
                end
                CMD_END:
                begin
                    for (int i = 0; i < MAX_TRUTHS; i++)
                    begin
                        if (!slot_valid[i]) continue;
                        p.truth_class = {1'b0, slot_class[i]};
                        p.predicted_class = NO_CLASS;
                        p.last = 1'b0;
                        pending_pairs.push_back(p);
                        slot_valid[i] = 1'b0;
                    end
                    // mark the final flush pair of this word
                    if (pending_pairs.size() > 0 && pending_pairs[$].predicted_class == NO_CLASS
                        && pending_pairs[$].last == 1'b0)
                        pending_pairs[$].last = 1'b1;
                    fill_count = 0;
                end
                default: ;
            endcase
        endfunction

        function void report(string what);
            $display("%0t mismatch: %s", $realtime, what);
            errors++;
        endfunction

        // compare one accepted result word with the oldest prediction
        function void check_pair(logic [15:0] data, logic last);
            pair_t p;
            if (pending_pairs.size() == 0)
            begin
                report($sformatf("unexpected word %h last %b", data, last));
                return;
            end
            p = pending_pairs.pop_front();
            if (data[7:0] !== p.truth_class)
                report($sformatf("truth_class %h, want %h", data[7:0], p.truth_class));
            if (data[15:8] !== p.predicted_class)
                report($sformatf("predicted_class %h, want %h", data[15:8],
                                 p.predicted_class));
            if (last !== p.last)
                report($sformatf("last %b, want %b", last, p.last));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // box_x, box_y, box_w, box_h, class_id, pad
    logic [1:0]  s_tuser;   // command
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // truth_class, predicted_class
    logic        m_tlast;

    pair_scoreboard sb;
    bit  sink_idle_ok;
    bit  hold_sink;
    bit  src_idle_ok;
    int  quiet_cycles;

    greedy_iou_detection_matcher dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // note inputs, check outputs and watch for a stuck block
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_item(cmd_t'(s_tuser), s_tdata[15:0], s_tdata[31:16],
                             s_tdata[47:32], s_tdata[63:48], s_tdata[70:64]);
            if (m_tvalid && m_tready)
                sb.check_pair(m_tdata, m_tlast);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("greedy_iou_detection_matcher verification failed");
                $finish;
            end
        end
    end

    // result side: random stall bursts, or one long counted hold-off
    initial
    begin
        int n;
        bit held;
        held = 1'b0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_sink && !held)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                held = 1'b1;
            end
            else if (sink_idle_ok && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 11);
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // offer one command word, hold it until accepted
    task automatic send_word(cmd_t cmd, logic [15:0] x, logic [15:0] y,
                             logic [15:0] w, logic [15:0] h, logic [6:0] cls);
        int n;
        if (src_idle_ok && $urandom_range(0, 4) == 0)
        begin
            n = $urandom_range(1, 11);
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, cls, h, w, y, x};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic send_rand(cmd_t cmd);
        send_word(cmd, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  7'($urandom));
    endtask

    // small boxes in a small field, so matches overlap often
    task automatic send_near(cmd_t cmd);
        send_word(cmd, 16'($urandom_range(0, 60)), 16'($urandom_range(0, 60)),
                  16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)), 7'($urandom));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_pairs.size() != 0) @(posedge clk);
    endtask

    initial
    begin
        int n_truths;
        int n_dets;
        sb = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_LOAD;
        sink_idle_ok = 1'b1;
        src_idle_ok = 1'b1;
        hold_sink = 1'b0;
        quiet_cycles = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: ghost, extremes, ties, no overlap, zero union
        send_word(CMD_MATCH, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'h7F);
        send_word(CMD_END, 0, 0, 0, 0, 0);
        send_word(CMD_LOAD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'h7F);
        send_word(CMD_LOAD, 0, 0, 0, 0, 7'h00);
        send_word(CMD_LOAD, 10, 10, 5, 5, 7'h11);
        send_word(CMD_LOAD, 10, 10, 5, 5, 7'h22);
        send_word(CMD_NONE, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 7'h55);
        send_word(CMD_MATCH, 10, 10, 5, 5, 7'h01);
        send_word(CMD_MATCH, 0, 0, 0, 0, 7'h02);
        send_word(CMD_MATCH, 1000, 1000, 3, 3, 7'h03);
        send_word(CMD_END, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'h7F);
        send_word(CMD_END, 0, 0, 0, 0, 0);
        send_word(CMD_LOAD, 0, 0, 100, 100, 7'h2A);
        send_word(CMD_LOAD, 50, 50, 100, 100, 7'h2B);
        send_word(CMD_END, 0, 0, 0, 0, 0);

        // store full: 70 loads, extra ones dropped, then matches; receiver given one long hold-off
        hold_sink = 1'b1;
        for (int i = 0; i < 70; i++) send_near(CMD_LOAD);
        for (int i = 0; i < 8; i++) send_near(CMD_MATCH);
        hold_sink = 1'b0;
        send_rand(CMD_END);
        wait_drained();

        // random images of mostly well-formed load/match/end sequences
        for (int img = 0; img < 8; img++)
        begin
            if (img == 6)
            begin
                sink_idle_ok = 1'b0;
                src_idle_ok = 1'b0;
            end
            n_truths = $urandom_range(0, 7);
            n_dets = $urandom_range(0, 8);
            for (int i = 0; i < n_truths; i++)
                if ($urandom_range(0, 3) == 0) send_rand(CMD_LOAD);
                else send_near(CMD_LOAD);
            for (int i = 0; i < n_dets; i++)
                case ($urandom_range(0, 9))
                    0: send_rand(CMD_MATCH);
                    1: send_rand(CMD_NONE);
                    2: send_near(CMD_LOAD);
                    default: send_near(CMD_MATCH);
                endcase
            send_rand(CMD_END);
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.errors == 0)
            $display("greedy_iou_detection_matcher verification clean");
        else
            $display("greedy_iou_detection_matcher verification failed");
        $finish;
    end

endmodule
